[rtl/core/djb2ht_pkg.sv]
// Shared constants for the djb2 chained hash table core.
package djb2ht_pkg;
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_VERIFY = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic [63:0] HASH_SEED = 64'd5381;
endpackage

[rtl/core/djb2_chained_hash_table_core.sv]
// Top level of the djb2 chained hash table core: hashing, table memories and sequencer.
// A beat with last low is taken while idle and busy stays low. A last beat holds busy for
// a dispatch state (S_HASH) plus the walk: insert scans the nodes for a free one (up to NODES),
// verify reads the bucket head, then reads and checks each chain node until a match or the
// chain end, remove walks the chain of every bucket in turn and unlinks the first key match;
// the single node memory port sets its length. done pulses for one cycle as busy drops; no stall.
// After reset a clearing pass over the head and used memories holds busy high.
module djb2_chained_hash_table_core #(
    parameter int BUCKETS = 256,
    parameter int NODES   = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [63:0] key,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        done,
    output logic        ok,
    output logic [1:0]  status
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = $clog2(NODES + 1);
    localparam int CW = ((BW > NW) ? BW : NW) + 1;
    localparam int SW = $clog2(NODES + 2) + 1;
    localparam logic [LW-1:0] NO_NODE = LW'(NODES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_INS_RD, S_INS_CHK, S_HEAD_RD, S_HEAD_WT,
        S_NODE_RD, S_NODE_CHK, S_UNLINK
    } state_t;

    // table memories
    logic [LW-1:0] head_mem [BUCKETS];
    logic          used_mem [NODES];
    logic [63:0]   key_mem  [NODES];
    logic [63:0]   hash_mem [NODES];
    logic [LW-1:0] next_mem [NODES];

    state_t        state_reg;
    logic [63:0]   hash_reg, key_reg;
    logic          ended_reg;
    logic [1:0]    op_reg;
    logic [CW-1:0] cnt_reg;
    logic [BW-1:0] bkt_reg;
    logic [LW-1:0] cur_reg, prev_reg;
    logic [SW-1:0] steps_reg;
    logic          done_reg, ok_reg;
    logic [1:0]    status_reg;

    // registered read data
    logic [LW-1:0] head_rd;
    logic          used_rd;
    logic [63:0]   key_rd, hash_rd;
    logic [LW-1:0] next_rd;

    // memory control
    logic          head_we, node_we, used_we, next_we;
    logic [BW-1:0] head_wa, head_ra;
    logic [LW-1:0] head_wd;
    logic [NW-1:0] node_wa, node_ra, used_wa, next_wa;
    logic          used_wd;
    logic [LW-1:0] next_wd;

    logic [63:0] step_hash;
    logic        hash_en;
    logic [63:0] sext;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign ok     = ok_reg;
    assign status = status_reg;

    // djb2 step on the accepted byte
    assign sext      = {{56{data_byte[7]}}, data_byte};
    assign step_hash = (hash_reg << 5) + hash_reg + sext;
    assign hash_en   = (op == djb2ht_pkg::OP_INSERT || op == djb2ht_pkg::OP_VERIFY)
                       && !ended_reg;

    // memory port drive
    always_comb
    begin
        head_we = 1'b0; head_wa = bkt_reg; head_wd = NO_NODE; head_ra = bkt_reg;
        node_we = 1'b0; node_wa = cnt_reg[NW-1:0]; node_ra = cnt_reg[NW-1:0];
        used_we = 1'b0; used_wa = cnt_reg[NW-1:0]; used_wd = 1'b0;
        next_we = 1'b0; next_wa = cnt_reg[NW-1:0]; next_wd = head_rd;
        case (state_reg)
            S_CLEAR:
            begin
                head_we = (cnt_reg < CW'(BUCKETS));
                head_wa = cnt_reg[BW-1:0];
                used_we = (cnt_reg < CW'(NODES));
            end
            S_INS_CHK:
            begin
                if (!used_rd)
                begin
                    node_we = 1'b1;
                    used_we = 1'b1; used_wd = 1'b1;
                    next_we = 1'b1;
                    head_we = 1'b1; head_wd = LW'(cnt_reg);
                end
            end
            S_NODE_RD, S_HEAD_WT, S_NODE_CHK:
            begin
                node_ra = cur_reg[NW-1:0];
            end
            S_UNLINK:
            begin
                used_we = 1'b1; used_wa = cur_reg[NW-1:0];
                if (prev_reg == NO_NODE)
                begin
                    head_we = 1'b1; head_wd = next_rd;
                end
                else
                begin
                    next_we = 1'b1; next_wa = prev_reg[NW-1:0]; next_wd = next_rd;
                end
            end
            default: ;
        endcase
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (head_we) head_mem[head_wa] <= head_wd;
        if (used_we) used_mem[used_wa] <= used_wd;
        if (next_we) next_mem[next_wa] <= next_wd;
        if (node_we)
        begin
            key_mem[node_wa]  <= key_reg;
            hash_mem[node_wa] <= hash_reg;
        end
        head_rd <= head_mem[head_ra];
        used_rd <= used_mem[node_ra];
        key_rd  <= key_mem[node_ra];
        hash_rd <= hash_mem[node_ra];
        next_rd <= next_mem[node_ra];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            hash_reg   <= djb2ht_pkg::HASH_SEED;
            ended_reg  <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            status_reg <= djb2ht_pkg::ST_DONE;
            op_reg     <= '0;
            key_reg    <= '0;
            bkt_reg    <= '0;
            cur_reg    <= '0;
            prev_reg   <= '0;
            steps_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    done_reg <= 1'b0;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg >= CW'(BUCKETS - 1) && cnt_reg >= CW'(NODES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        if (hash_en)
                        begin
                            if (data_byte == 8'd0) ended_reg <= 1'b1;
                            else hash_reg <= step_hash;
                        end
                        if (last)
                        begin
                            op_reg  <= op;
                            key_reg <= key;
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    cnt_reg  <= '0;
                    prev_reg <= NO_NODE;
                    steps_reg <= '0;
                    case (op_reg)
                        djb2ht_pkg::OP_INSERT:
                        begin
                            done_reg  <= 1'b0;
                            bkt_reg   <= hash_reg[BW-1:0];
                            state_reg <= S_INS_RD;
                        end
                        djb2ht_pkg::OP_VERIFY:
                        begin
                            done_reg  <= 1'b0;
                            bkt_reg   <= hash_reg[BW-1:0];
                            state_reg <= S_HEAD_RD;
                        end
                        djb2ht_pkg::OP_REMOVE:
                        begin
                            done_reg  <= 1'b0;
                            bkt_reg   <= '0;
                            state_reg <= S_HEAD_RD;
                        end
                        default:
                        begin
                            ok_reg <= 1'b0; status_reg <= djb2ht_pkg::ST_MISS;
                            done_reg <= 1'b1;
                            hash_reg <= djb2ht_pkg::HASH_SEED; ended_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_INS_RD:
                begin
                    // read of used[cnt] and head[bkt] issued
                    done_reg <= 1'b0;
                    state_reg <= S_INS_CHK;
                end
                S_INS_CHK:
                begin
                    if (!used_rd)
                    begin
                        ok_reg <= 1'b1; status_reg <= djb2ht_pkg::ST_DONE;
                        done_reg <= 1'b1;
                        hash_reg <= djb2ht_pkg::HASH_SEED; ended_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else if (cnt_reg == CW'(NODES - 1))
                    begin
                        ok_reg <= 1'b0; status_reg <= djb2ht_pkg::ST_FULL;
                        done_reg <= 1'b1;
                        hash_reg <= djb2ht_pkg::HASH_SEED; ended_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= S_INS_RD;
                    end
                end
                S_HEAD_RD:
                begin
                    done_reg <= 1'b0;
                    state_reg <= S_HEAD_WT;
                end
                S_HEAD_WT:
                begin
                    done_reg  <= 1'b0;
                    cur_reg   <= head_rd;
                    prev_reg  <= NO_NODE;
                    steps_reg <= '0;
                    state_reg <= S_NODE_RD;
                end
                S_NODE_RD:
                begin
                    // chain end or step bound
                    if (cur_reg >= NO_NODE || steps_reg >= SW'(NODES))
                    begin
                        if (op_reg == djb2ht_pkg::OP_REMOVE
                            && bkt_reg != BW'(BUCKETS - 1))
                        begin
                            done_reg  <= 1'b0;
                            bkt_reg   <= bkt_reg + 1'b1;
                            state_reg <= S_HEAD_RD;
                        end
                        else
                        begin
                            ok_reg <= 1'b0; status_reg <= djb2ht_pkg::ST_MISS;
                            done_reg <= 1'b1;
                            hash_reg <= djb2ht_pkg::HASH_SEED; ended_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        done_reg  <= 1'b0;
                        state_reg <= S_NODE_CHK;
                    end
                end
                S_NODE_CHK:
                begin
                    if (used_rd && key_rd == key_reg
                        && (op_reg == djb2ht_pkg::OP_REMOVE || hash_rd == hash_reg))
                    begin
                        if (op_reg == djb2ht_pkg::OP_REMOVE)
                        begin
                            done_reg  <= 1'b0;
                            state_reg <= S_UNLINK;
                        end
                        else
                        begin
                            ok_reg <= 1'b1; status_reg <= djb2ht_pkg::ST_DONE;
                            done_reg <= 1'b1;
                            hash_reg <= djb2ht_pkg::HASH_SEED; ended_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        done_reg  <= 1'b0;
                        prev_reg  <= cur_reg;
                        cur_reg   <= next_rd;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_NODE_RD;
                    end
                end
                S_UNLINK:
                begin
                    ok_reg <= 1'b1; status_reg <= djb2ht_pkg::ST_DONE;
                    done_reg <= 1'b1;
                    hash_reg <= djb2ht_pkg::HASH_SEED; ended_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[sim/testbench.sv]
// Self-checking testbench for the djb2 chained hash table core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUCKETS = 256;
    localparam int NUM_NODES   = 1024;
    localparam int NO_LINK     = NUM_NODES;
    localparam int RANDOM_OPS  = 375;
    localparam int IDLE_LIMIT  = 40000;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [1:0] status;
    } outcome_t;

    // Table mirror and expected outcomes
    class table_scoreboard;
        logic [63:0] accum;
        bit          ended;
        int          head [NUM_BUCKETS];
        bit          used [NUM_NODES];
        logic [63:0] nkey [NUM_NODES];
        logic [63:0] nhash [NUM_NODES];
        int          nnext [NUM_NODES];
        outcome_t    pending [$];
        int          errors;

        function new();
            accum = djb2ht_pkg::HASH_SEED;
            ended = 0;
            errors = 0;
            foreach (head[i]) head[i] = NO_LINK;
            foreach (used[i]) used[i] = 0;
        endfunction

        function bit table_insert(logic [63:0] k, logic [63:0] h);
            int b;
            b = int'(h[7:0]);
            for (int n = 0; n < NUM_NODES; n++) begin
                if (!used[n]) begin
                    used[n] = 1;
                    nkey[n] = k;
                    nhash[n] = h;
                    nnext[n] = head[b];
                    head[b] = n;
                    return 1;
                end
            end
            return 0;
        endfunction

        function bit table_lookup(logic [63:0] k, logic [63:0] h);
            int cur;
            cur = head[int'(h[7:0])];
            for (int s = 0; s < NUM_NODES && cur < NUM_NODES; s++) begin
                if (used[cur] && nkey[cur] == k && nhash[cur] == h) return 1;
                cur = nnext[cur];
            end
            return 0;
        endfunction

        function bit table_remove(logic [63:0] k);
            int cur;
            int prev;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                cur = head[b];
                prev = NO_LINK;
                for (int s = 0; s < NUM_NODES && cur < NUM_NODES; s++) begin
                    if (used[cur] && nkey[cur] == k) begin
                        if (prev >= NUM_NODES) head[b] = nnext[cur];
                        else nnext[prev] = nnext[cur];
                        used[cur] = 0;
                        return 1;
                    end
                    prev = cur;
                    cur = nnext[cur];
                end
            end
            return 0;
        endfunction

        // Advance the hash on one accepted beat, predict the outcome on last
        function void note_beat(logic [1:0] o, logic [63:0] k, logic [7:0] d, logic l);
            outcome_t r;
            if ((o == djb2ht_pkg::OP_INSERT || o == djb2ht_pkg::OP_VERIFY) && !ended) begin
                if (d == 8'd0) ended = 1;
                else accum = (accum << 5) + accum + {{56{d[7]}}, d};
            end
            if (!l) return;
            r.ok = 0;
            r.status = djb2ht_pkg::ST_MISS;
            if (o == djb2ht_pkg::OP_INSERT) begin
                r.ok = table_insert(k, accum);
                r.status = r.ok ? djb2ht_pkg::ST_DONE : djb2ht_pkg::ST_FULL;
            end else if (o == djb2ht_pkg::OP_VERIFY) begin
                r.ok = table_lookup(k, accum);
                r.status = r.ok ? djb2ht_pkg::ST_DONE : djb2ht_pkg::ST_MISS;
            end else if (o == djb2ht_pkg::OP_REMOVE) begin
                r.ok = table_remove(k);
                r.status = r.ok ? djb2ht_pkg::ST_DONE : djb2ht_pkg::ST_MISS;
            end
            accum = djb2ht_pkg::HASH_SEED;
            ended = 0;
            pending.push_back(r);
        endfunction

        function void check_result(logic a_ok, logic [1:0] a_status);
            outcome_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result ok=%0d status=%0d", $time, a_ok, a_status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a_ok !== e.ok) begin
                $display("%0t: ok expected %0d actual %0d", $time, e.ok, a_ok);
                errors++;
            end
            if (a_status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, a_status);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [63:0] key;
    logic [7:0]  data_byte;
    logic        last;
    logic        done;
    logic        ok;
    logic [1:0]  status;

    table_scoreboard tracker;
    int              idle_cycles;
    logic [63:0]     key_pool [16];

    djb2_chained_hash_table_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .key       (key),
        .data_byte (data_byte),
        .last      (last),
        .done      (done),
        .ok        (ok),
        .status    (status)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Check results and watch for a stalled run
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done) tracker.check_result(ok, status);
            if ((start && !busy) || done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Drive one beat and hold it until accepted; an optional gap comes first
    task automatic send_beat(logic [1:0] o, logic [63:0] k, logic [7:0] d, logic l);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge clk);
        end
        start <= 1;
        op <= o;
        key <= k;
        data_byte <= d;
        last <= l;
        do @(posedge clk); while (busy);
        tracker.note_beat(o, k, d, l);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r < 3) return 8'h80 | 8'($urandom_range(0, 127));
        if (r < 5) return 8'($urandom_range(1, 3));
        return 8'($urandom_range(1, 255));
    endfunction

    // Stream one string then end the operation
    task automatic send_op(logic [1:0] o, logic [63:0] k, int len);
        for (int i = 0; i < len; i++) send_beat(o, '0, pick_byte(), 0);
        send_beat(o, k, pick_byte(), 1);
    endtask

    task automatic send_string(logic [1:0] o, logic [63:0] k, logic [7:0] s []);
        for (int i = 0; i < s.size(); i++) send_beat(o, k, s[i], i == s.size() - 1);
    endtask

    initial begin
        logic [1:0]  o;
        logic [63:0] k;
        int          r;
        tracker = new();
        idle_cycles = 0;
        start = 0;
        op = djb2ht_pkg::OP_INSERT;
        key = '0;
        data_byte = '0;
        last = 0;
        rst_n = 0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, each op, zero byte, bytes after end, mixed and unknown ops
        send_string(djb2ht_pkg::OP_INSERT, '0, '{8'h61, 8'hFF});
        send_string(djb2ht_pkg::OP_VERIFY, '0, '{8'h61, 8'hFF});
        send_string(djb2ht_pkg::OP_VERIFY, '1, '{8'h61, 8'hFF});
        send_string(djb2ht_pkg::OP_INSERT, '1, '{8'h80, 8'h00, 8'h7F});
        send_string(djb2ht_pkg::OP_VERIFY, '1, '{8'h80, 8'h00, 8'h55});
        send_string(djb2ht_pkg::OP_INSERT, 64'h5555_AAAA_0F0F_F0F0, '{8'h00});
        send_beat(djb2ht_pkg::OP_REMOVE, 64'h1234, 8'hAA, 0);
        send_string(djb2ht_pkg::OP_VERIFY, 64'h5555_AAAA_0F0F_F0F0, '{8'h00});
        send_beat(djb2ht_pkg::OP_REMOVE, '0, 8'h00, 1);
        send_beat(djb2ht_pkg::OP_REMOVE, '0, 8'hFF, 1);
        send_string(djb2ht_pkg::OP_VERIFY, '0, '{8'h61, 8'hFF});
        send_beat(OP_UNKNOWN, '1, 8'h12, 0);
        send_beat(djb2ht_pkg::OP_VERIFY, '1, 8'h80, 0);
        send_beat(djb2ht_pkg::OP_REMOVE, '1, 8'h00, 0);
        send_beat(djb2ht_pkg::OP_VERIFY, '1, 8'h00, 1);
        send_beat(OP_UNKNOWN, '1, 8'h01, 1);
        send_beat(djb2ht_pkg::OP_REMOVE, '1, 8'h01, 1);

        // Random: mostly well-formed ops on a small key set, some noise
        for (int n = 0; n < RANDOM_OPS; n++) begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : key_pool[$urandom_range(0, 15)];
            if (r < 40) o = djb2ht_pkg::OP_INSERT;
            else if (r < 75) o = djb2ht_pkg::OP_VERIFY;
            else if (r < 92) o = djb2ht_pkg::OP_REMOVE;
            else o = OP_UNKNOWN;
            if (r >= 97) send_beat(2'($urandom), k, 8'($urandom), 1'($urandom_range(0, 1)));
            else send_op(o, k, (o == djb2ht_pkg::OP_REMOVE) ? 0 : $urandom_range(0, 3));
        end
        start <= 0;

        // Drain outstanding results, then let the block settle
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[djb2_chained_hash_table_core.f]
rtl/core/djb2ht_pkg.sv
rtl/core/djb2_chained_hash_table_core.sv
sim/testbench.sv
